// ===== src/imp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// imp_pkg
// Shared widths, memory entry codes and the frame summary type of the
// peak-centered image moments block.
// ----------------------------------------------------------------------------
package imp_pkg;

	localparam int MAX_SIDE  = 256;
	localparam int PIX_W     = 16;
	localparam int FRAC_BITS = 8;
	localparam int SIDE_W    = 9;
	localparam int POS_W     = 8;

	localparam int SUM_W = 33;  // intensity sum
	localparam int WX_W  = 41;  // first order sums
	localparam int SQ_W  = 49;  // second order sums
	localparam int ACC_W = 52;  // signed work width of the centering step
	localparam int SQP_W = 2 * POS_W;

	localparam int DIVN_W = SQ_W + FRAC_BITS;
	localparam int CNT_W  = $clog2(DIVN_W);
	localparam int Q_W    = 25;

	localparam int MEM_DEPTH = 6;
	localparam int MEM_AW    = 3;

	// Entries of the accumulator memory.
	localparam logic [MEM_AW-1:0] ENT_SUM = 3'd0;
	localparam logic [MEM_AW-1:0] ENT_X   = 3'd1;
	localparam logic [MEM_AW-1:0] ENT_Y   = 3'd2;
	localparam logic [MEM_AW-1:0] ENT_XX  = 3'd3;
	localparam logic [MEM_AW-1:0] ENT_XY  = 3'd4;
	localparam logic [MEM_AW-1:0] ENT_YY  = 3'd5;

	localparam logic CFG_COLUMNS = 1'b0;
	localparam logic CFG_ROWS    = 1'b1;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [WX_W-1:0]  sx;
		logic [WX_W-1:0]  sy;
		logic [SQ_W-1:0]  sxx;
		logic [SQ_W-1:0]  sxy;
		logic [SQ_W-1:0]  syy;
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
		logic [PIX_W-1:0] maxv;
		logic [PIX_W-1:0] minv;
	} imp_frame_t;

endpackage
`default_nettype wire

// ===== src/image_moments_peak_centered_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// image_moments_peak_centered_top
// Per-frame intensity moments about the first strict peak.
// ----------------------------------------------------------------------------
// Pixels arrive column by column, row index running fastest, with the frame
// size taken from the columns and rows registers (0 acts as 1, values above
// 256 act as 256). Each pixel is accepted, its squared coordinates are formed,
// and six read-modify-write passes go over the six-entry accumulator memory
// with a final write-back, and the next pixel waits for it. After the last
// pixel of a frame the sums are centered on the peak and divided by the
// intensity sum (seven shared multiply steps and five divisions, skipped when
// the sum is zero); no pixel is taken during that time. After reset a clearing
// pass zeroes the accumulator memory before the first pixel is taken.
// The result word is held in an output register until it is taken.
module image_moments_peak_centered_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic                         cfg_index,
	input  wire logic [imp_pkg::SIDE_W-1:0]   cfg_data,
	input  wire logic                         pixel_valid,
	output logic                              pixel_stall,
	input  wire logic [imp_pkg::PIX_W-1:0]    pixel,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic [15:0]                       centroid_x,
	output logic [15:0]                       centroid_y,
	output logic [23:0]                       moment_xx,
	output logic signed [24:0]                moment_xy,
	output logic [23:0]                       moment_yy,
	output logic [imp_pkg::POS_W-1:0]         peak_x,
	output logic [imp_pkg::POS_W-1:0]         peak_y,
	output logic [imp_pkg::PIX_W-1:0]         max_value,
	output logic [imp_pkg::PIX_W-1:0]         min_value,
	output logic                              zero_sum
);
	import imp_pkg::*;

	localparam logic [2:0] A_CLR  = 3'd0;
	localparam logic [2:0] A_IDLE = 3'd1;
	localparam logic [2:0] A_SQ   = 3'd2;
	localparam logic [2:0] A_RMW  = 3'd3;
	localparam logic [2:0] A_WB   = 3'd4;

	logic [SIDE_W-1:0]  columns_q, rows_q;
	logic [SIDE_W-1:0]  ncol, nrow;
	logic [2:0]         st_q;
	logic [MEM_AW-1:0]  idx_q;
	logic [POS_W-1:0]   col_q, row_q;
	logic [PIX_W-1:0]   largest_q, smallest_q;
	logic [POS_W-1:0]   peak_col_q, peak_row_q;
	logic [PIX_W-1:0]   largest_n, smallest_n;
	logic [POS_W-1:0]   peak_col_n, peak_row_n;
	logic               row_end, col_end, accept, first;
	logic [PIX_W-1:0]   p_q;
	logic [POS_W-1:0]   x_q, y_q;
	logic               last_q;
	logic [SQP_W-1:0]   xx_q, xy_q, yy_q;
	logic [PIX_W-1:0]   coef;
	logic [2*PIX_W-1:0] prod_s1;
	logic               wr_s1;
	logic [MEM_AW-1:0]  widx_s1;
	logic [SQ_W-1:0]    acc_mem [MEM_DEPTH];
	logic [SQ_W-1:0]    rdata_q;
	logic [SQ_W-1:0]    sum_new;
	logic               mem_we;
	logic [MEM_AW-1:0]  mem_waddr;
	logic [SQ_W-1:0]    mem_wdata;
	logic               go_q;
	logic               fin_busy;
	imp_frame_t         frame_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= SIDE_W'(MAX_SIDE);
			rows_q    <= SIDE_W'(MAX_SIDE);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_COLUMNS: columns_q <= cfg_data;
				CFG_ROWS:    rows_q    <= cfg_data;
				default:     rows_q    <= rows_q;
			endcase
		end
	end

	assign ncol = (columns_q == '0) ? SIDE_W'(1) :
	              (columns_q > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : columns_q;
	assign nrow = (rows_q == '0) ? SIDE_W'(1) :
	              (rows_q > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : rows_q;

	assign pixel_stall = (st_q != A_IDLE) || fin_busy || go_q;
	assign accept      = pixel_valid && !pixel_stall;
	assign first       = (col_q == '0) && (row_q == '0);
	assign row_end     = ({1'b0, row_q} + 1'b1) >= nrow;
	assign col_end     = ({1'b0, col_q} + 1'b1) >= ncol;

	// Peak and extremes as they stand after the pixel now offered.
	always_comb begin
		largest_n  = largest_q;
		smallest_n = smallest_q;
		peak_col_n = peak_col_q;
		peak_row_n = peak_row_q;
		if (first) begin
			largest_n  = pixel;
			smallest_n = pixel;
			peak_col_n = '0;
			peak_row_n = '0;
		end else begin
			if (pixel > largest_q) begin
				largest_n  = pixel;
				peak_col_n = col_q;
				peak_row_n = row_q;
			end
			if (pixel < smallest_q) smallest_n = pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= A_CLR;
			idx_q      <= '0;
			col_q      <= '0;
			row_q      <= '0;
			largest_q  <= '0;
			smallest_q <= '0;
			peak_col_q <= '0;
			peak_row_q <= '0;
			last_q     <= 1'b0;
			wr_s1      <= 1'b0;
			go_q       <= 1'b0;
		end else begin
			go_q  <= 1'b0;
			wr_s1 <= (st_q == A_RMW);
			unique case (st_q)
				A_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == MEM_AW'(MEM_DEPTH - 1)) begin
						idx_q <= '0;
						st_q  <= A_IDLE;
					end
				end
				A_IDLE: begin
					if (accept) begin
						largest_q  <= largest_n;
						smallest_q <= smallest_n;
						peak_col_q <= peak_col_n;
						peak_row_q <= peak_row_n;
						last_q     <= row_end && col_end;
						if (row_end) begin
							row_q <= '0;
							col_q <= col_end ? '0 : col_q + 1'b1;
						end else begin
							row_q <= row_q + 1'b1;
						end
						st_q <= A_SQ;
					end
				end
				A_SQ: begin
					idx_q <= '0;
					st_q  <= A_RMW;
				end
				A_RMW: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == MEM_AW'(MEM_DEPTH - 1)) st_q <= A_WB;
				end
				A_WB: begin
					idx_q <= '0;
					go_q  <= last_q;
					st_q  <= A_IDLE;
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_q <= pixel;
			x_q <= col_q;
			y_q <= row_q;
			if (row_end && col_end) begin
				frame_q.px   <= peak_col_n;
				frame_q.py   <= peak_row_n;
				frame_q.maxv <= largest_n;
				frame_q.minv <= smallest_n;
			end
		end
		if (st_q == A_SQ) begin
			xx_q <= x_q * x_q;
			xy_q <= x_q * y_q;
			yy_q <= y_q * y_q;
		end
		if (st_q == A_RMW) begin
			prod_s1 <= coef * p_q;
			widx_s1 <= idx_q;
		end
		// The finished sums of a frame leave the memory here; zeros go back.
		if (wr_s1 && last_q) begin
			unique case (widx_s1)
				ENT_SUM: frame_q.sum <= sum_new[SUM_W-1:0];
				ENT_X:   frame_q.sx  <= sum_new[WX_W-1:0];
				ENT_Y:   frame_q.sy  <= sum_new[WX_W-1:0];
				ENT_XX:  frame_q.sxx <= sum_new;
				ENT_XY:  frame_q.sxy <= sum_new;
				ENT_YY:  frame_q.syy <= sum_new;
				default: frame_q.syy <= frame_q.syy;
			endcase
		end
	end

	always_comb begin
		unique case (idx_q)
			ENT_SUM: coef = PIX_W'(1);
			ENT_X:   coef = PIX_W'(x_q);
			ENT_Y:   coef = PIX_W'(y_q);
			ENT_XX:  coef = xx_q;
			ENT_XY:  coef = xy_q;
			ENT_YY:  coef = yy_q;
			default: coef = '0;
		endcase
	end

	assign sum_new   = rdata_q + SQ_W'(prod_s1);
	assign mem_we    = wr_s1 || (st_q == A_CLR);
	assign mem_waddr = (st_q == A_CLR) ? idx_q : widx_s1;
	assign mem_wdata = ((st_q == A_CLR) || last_q) ? '0 : sum_new;

	always_ff @(posedge clk) begin
		if (mem_we) acc_mem[mem_waddr] <= mem_wdata;
		if (st_q == A_RMW) rdata_q <= acc_mem[idx_q];
	end

	imp_final u_final (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go_q),
		.frame        (frame_q),
		.busy         (fin_busy),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.centroid_x   (centroid_x),
		.centroid_y   (centroid_y),
		.moment_xx    (moment_xx),
		.moment_xy    (moment_xy),
		.moment_yy    (moment_yy),
		.peak_x       (peak_x),
		.peak_y       (peak_y),
		.max_value    (max_value),
		.min_value    (min_value),
		.zero_sum     (zero_sum)
	);

endmodule
`default_nettype wire

// ===== src/imp_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// imp_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^FRAC / den),
// keeping the low quotient bits.
// ----------------------------------------------------------------------------
module imp_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [imp_pkg::SQ_W-1:0]   num,
	input  wire logic [imp_pkg::SUM_W-1:0]  den,
	output logic                            done,
	output logic [imp_pkg::Q_W-1:0]         quo
);
	import imp_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   rem_q;
	logic [DIVN_W-1:0]  sh_q;
	logic [Q_W-1:0]     quo_q;
	logic [SUM_W:0]     trial;
	logic               ge;
	logic [SUM_W:0]     diff;

	assign trial = {rem_q, sh_q[DIVN_W-1]};
	assign ge    = trial >= {1'b0, den};
	assign diff  = trial - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= {num, {FRAC_BITS{1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
			sh_q  <= {sh_q[DIVN_W-2:0], 1'b0};
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

// ===== src/imp_final.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// imp_final
// End of frame: moves the raw second sums to the peak, divides by the
// intensity sum (unless it is zero) and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module imp_final (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire imp_pkg::imp_frame_t         frame,
	output logic                             busy,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output logic [15:0]                      centroid_x,
	output logic [15:0]                      centroid_y,
	output logic [23:0]                      moment_xx,
	output logic signed [24:0]               moment_xy,
	output logic [23:0]                      moment_yy,
	output logic [imp_pkg::POS_W-1:0]        peak_x,
	output logic [imp_pkg::POS_W-1:0]        peak_y,
	output logic [imp_pkg::PIX_W-1:0]        max_value,
	output logic [imp_pkg::PIX_W-1:0]        min_value,
	output logic                             zero_sum
);
	import imp_pkg::*;

	localparam logic [2:0] F_IDLE   = 3'd0;
	localparam logic [2:0] F_SQ     = 3'd1;
	localparam logic [2:0] F_MUL    = 3'd2;
	localparam logic [2:0] F_DSTART = 3'd3;
	localparam logic [2:0] F_DWAIT  = 3'd4;
	localparam logic [2:0] F_OUT    = 3'd5;

	// Correction steps: each adds one product, or twice it, to a sum or takes it from one.
	localparam logic [2:0] M_PX_SX  = 3'd0;
	localparam logic [2:0] M_PXX_S  = 3'd1;
	localparam logic [2:0] M_PY_SY  = 3'd2;
	localparam logic [2:0] M_PYY_S  = 3'd3;
	localparam logic [2:0] M_PX_SY  = 3'd4;
	localparam logic [2:0] M_PY_SX  = 3'd5;
	localparam logic [2:0] M_PXY_S  = 3'd6;

	// Quotient order.
	localparam logic [2:0] Q_CX  = 3'd0;
	localparam logic [2:0] Q_CY  = 3'd1;
	localparam logic [2:0] Q_MXX = 3'd2;
	localparam logic [2:0] Q_MXY = 3'd3;
	localparam logic [2:0] Q_MYY = 3'd4;

	logic [2:0]              st_q;
	logic [2:0]              step_q;
	logic                    ph_q;
	logic [2:0]              qidx_q;
	logic [SQP_W-1:0]        pxx_q, pyy_q, pxy_q;
	logic [ACC_W-1:0]        cxx_q, cyy_q, cxy_q;
	logic [WX_W+PIX_W-1:0]   prod_q;
	logic [WX_W-1:0]         mul_a;
	logic [PIX_W-1:0]        mul_b;
	logic [ACC_W-1:0]        prod_lo;
	logic [ACC_W-1:0]        prod_x2;
	logic [ACC_W-1:0]        cxy_mag;
	logic [SQ_W-1:0]         div_num;
	logic                    div_start;
	logic                    div_done;
	logic [Q_W-1:0]          div_quo;
	logic [15:0]             cx_q, cy_q;
	logic [23:0]             mxx_q, myy_q;
	logic [24:0]             mxy_q;
	logic                    zs_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (step_q)
			M_PX_SX: begin mul_a = frame.sx;            mul_b = PIX_W'(frame.px); end
			M_PXX_S: begin mul_a = WX_W'(frame.sum);    mul_b = pxx_q; end
			M_PY_SY: begin mul_a = frame.sy;            mul_b = PIX_W'(frame.py); end
			M_PYY_S: begin mul_a = WX_W'(frame.sum);    mul_b = pyy_q; end
			M_PX_SY: begin mul_a = frame.sy;            mul_b = PIX_W'(frame.px); end
			M_PY_SX: begin mul_a = frame.sx;            mul_b = PIX_W'(frame.py); end
			M_PXY_S: begin mul_a = WX_W'(frame.sum);    mul_b = pxy_q; end
			default: begin mul_a = '0;                  mul_b = '0; end
		endcase
	end

	assign prod_lo = prod_q[ACC_W-1:0];
	assign prod_x2 = {prod_lo[ACC_W-2:0], 1'b0};
	assign cxy_mag = cxy_q[ACC_W-1] ? (~cxy_q + 1'b1) : cxy_q;

	always_comb begin
		unique case (qidx_q)
			Q_CX:    div_num = SQ_W'(frame.sx);
			Q_CY:    div_num = SQ_W'(frame.sy);
			Q_MXX:   div_num = cxx_q[ACC_W-1] ? '0 : cxx_q[SQ_W-1:0];
			Q_MXY:   div_num = cxy_mag[SQ_W-1:0];
			Q_MYY:   div_num = cyy_q[ACC_W-1] ? '0 : cyy_q[SQ_W-1:0];
			default: div_num = '0;
		endcase
	end

	assign div_start = (st_q == F_DSTART);

	imp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (frame.sum),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= F_IDLE;
			step_q       <= '0;
			ph_q         <= 1'b0;
			qidx_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
			unique case (st_q)
				F_IDLE: begin
					if (go) st_q <= F_SQ;
				end
				F_SQ: begin
					step_q <= M_PX_SX;
					ph_q   <= 1'b0;
					qidx_q <= Q_CX;
					st_q   <= (frame.sum == '0) ? F_OUT : F_MUL;
				end
				F_MUL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						step_q <= step_q + 1'b1;
						if (step_q == M_PXY_S) st_q <= F_DSTART;
					end
				end
				F_DSTART: st_q <= F_DWAIT;
				F_DWAIT: begin
					if (div_done) begin
						qidx_q <= qidx_q + 1'b1;
						st_q   <= (qidx_q == Q_MYY) ? F_OUT : F_DSTART;
					end
				end
				F_OUT: begin
					if (!result_valid) begin
						result_valid <= 1'b1;
						st_q         <= F_IDLE;
					end
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == F_SQ) begin
			pxx_q <= frame.px * frame.px;
			pyy_q <= frame.py * frame.py;
			pxy_q <= frame.px * frame.py;
			cxx_q <= ACC_W'(frame.sxx);
			cyy_q <= ACC_W'(frame.syy);
			cxy_q <= ACC_W'(frame.sxy);
			zs_q  <= (frame.sum == '0);
			cx_q  <= '0;
			cy_q  <= '0;
			mxx_q <= '0;
			mxy_q <= '0;
			myy_q <= '0;
		end
		if (st_q == F_MUL) begin
			if (!ph_q) begin
				prod_q <= mul_a * mul_b;
			end else begin
				unique case (step_q)
					M_PX_SX: cxx_q <= cxx_q - prod_x2;
					M_PXX_S: cxx_q <= cxx_q + prod_lo;
					M_PY_SY: cyy_q <= cyy_q - prod_x2;
					M_PYY_S: cyy_q <= cyy_q + prod_lo;
					M_PX_SY: cxy_q <= cxy_q - prod_lo;
					M_PY_SX: cxy_q <= cxy_q - prod_lo;
					M_PXY_S: cxy_q <= cxy_q + prod_lo;
					default: cxy_q <= cxy_q;
				endcase
			end
		end
		if (st_q == F_DWAIT && div_done) begin
			unique case (qidx_q)
				Q_CX:    cx_q  <= div_quo[15:0];
				Q_CY:    cy_q  <= div_quo[15:0];
				Q_MXX:   mxx_q <= div_quo[23:0];
				Q_MXY:   mxy_q <= cxy_q[ACC_W-1] ? (~div_quo + 1'b1) : div_quo;
				Q_MYY:   myy_q <= div_quo[23:0];
				default: myy_q <= myy_q;
			endcase
		end
		if (st_q == F_OUT && !result_valid) begin
			centroid_x <= cx_q;
			centroid_y <= cy_q;
			moment_xx  <= mxx_q;
			moment_xy  <= mxy_q;
			moment_yy  <= myy_q;
			peak_x     <= frame.px;
			peak_y     <= frame.py;
			max_value  <= frame.maxv;
			min_value  <= frame.minv;
			zero_sum   <= zs_q;
		end
	end

	assign busy = (st_q != F_IDLE);

endmodule
`default_nettype wire

// ===== src/imp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// imp_checker
// Port-level checks on the result channel of the image moments block.
// ----------------------------------------------------------------------------
module imp_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       result_valid,
	input wire logic                       result_stall,
	input wire logic [15:0]                centroid_x,
	input wire logic [15:0]                centroid_y,
	input wire logic [23:0]                moment_xx,
	input wire logic [24:0]                moment_xy,
	input wire logic [imp_pkg::PIX_W-1:0]  max_value,
	input wire logic [imp_pkg::PIX_W-1:0]  min_value,
	input wire logic                       zero_sum
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(moment_xx) && $stable(centroid_x))
		else $error("result word changed while stalled");

	a_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && zero_sum |-> centroid_x == 16'd0 && centroid_y == 16'd0
			&& moment_xx == 24'd0 && moment_xy == 25'd0)
		else $error("zero intensity sum with nonzero quotient");

	a_extremes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> max_value >= min_value)
		else $error("maximum below minimum");

endmodule

bind image_moments_peak_centered_top imp_checker u_imp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.centroid_x   (centroid_x),
	.centroid_y   (centroid_y),
	.moment_xx    (moment_xx),
	.moment_xy    (moment_xy),
	.max_value    (max_value),
	.min_value    (min_value),
	.zero_sum     (zero_sum)
);
`default_nettype wire

// ===== test/image_moments_checker.sv =====
// ----------------------------------------------------------------------------
// image_moments_checker
// Watches the configuration, pixel and result channels of the peak-centered
// moments block, keeps its own running frame sums, predicts the summary word
// at each frame end and compares every returned word field by field.
// ----------------------------------------------------------------------------
module image_moments_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	input  wire logic                       cfg_ready,
	input  wire logic                       cfg_index,
	input  wire logic [imp_pkg::SIDE_W-1:0] cfg_data,
	input  wire logic                       pixel_valid,
	input  wire logic                       pixel_stall,
	input  wire logic [imp_pkg::PIX_W-1:0]  pixel,
	input  wire logic                       result_valid,
	input  wire logic                       result_stall,
	input  wire logic [15:0]                centroid_x,
	input  wire logic [15:0]                centroid_y,
	input  wire logic [23:0]                moment_xx,
	input  wire logic signed [24:0]         moment_xy,
	input  wire logic [23:0]                moment_yy,
	input  wire logic [7:0]                 peak_x,
	input  wire logic [7:0]                 peak_y,
	input  wire logic [15:0]                max_value,
	input  wire logic [15:0]                min_value,
	input  wire logic                       zero_sum,
	output int                              errors,
	output int                              pending,
	output logic                            frame_open
);
	import imp_pkg::*;

	typedef struct {
		logic [15:0] cx;
		logic [15:0] cy;
		logic [23:0] mxx;
		logic [24:0] mxy;
		logic [23:0] myy;
		logic [7:0]  px;
		logic [7:0]  py;
		logic [15:0] maxv;
		logic [15:0] minv;
		logic        zs;
	} summary_t;

	summary_t summary_q[$];

	logic [SIDE_W-1:0] width_reg, height_reg;
	longint sum_i, sum_xi, sum_yi, sum_xxi, sum_xyi, sum_yyi;
	logic [15:0] hi_val, lo_val;
	int col, row, peak_c, peak_r;

	function automatic int eff_side(logic [SIDE_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_SIDE) return MAX_SIDE;
		return int'(v);
	endfunction

	// Fixed-point quotient with FRAC_BITS fraction bits, truncated.
	function automatic longint fixed_quot(longint n, longint d);
		return ((n / d) <<< FRAC_BITS) + (((n % d) <<< FRAC_BITS) / d);
	endfunction

	function automatic void clear_sums();
		sum_i = 0; sum_xi = 0; sum_yi = 0;
		sum_xxi = 0; sum_xyi = 0; sum_yyi = 0;
		hi_val = 0; lo_val = 0;
		peak_c = 0; peak_r = 0; col = 0; row = 0;
	endfunction

	function automatic void take_pixel(logic [15:0] p);
		longint pv, cxx, cyy, cxy, px, py;
		summary_t s;
		pv = longint'(p);
		if (col == 0 && row == 0) begin
			hi_val = p; lo_val = p; peak_c = 0; peak_r = 0;
		end else begin
			if (p > hi_val) begin
				hi_val = p; peak_c = col; peak_r = row;
			end
			if (p < lo_val) lo_val = p;
		end
		sum_i += pv;
		sum_xi += col * pv;
		sum_yi += row * pv;
		sum_xxi += longint'(col * col) * pv;
		sum_xyi += longint'(col * row) * pv;
		sum_yyi += longint'(row * row) * pv;
		if (row + 1 < eff_side(height_reg)) begin
			row++;
			return;
		end
		row = 0;
		if (col + 1 < eff_side(width_reg)) begin
			col++;
			return;
		end
		s = '{default: '0};
		px = peak_c; py = peak_r;
		if (sum_i != 0) begin
			cxx = sum_xxi - 2 * px * sum_xi + px * px * sum_i;
			cyy = sum_yyi - 2 * py * sum_yi + py * py * sum_i;
			cxy = sum_xyi - px * sum_yi - py * sum_xi + px * py * sum_i;
			s.cx = fixed_quot(sum_xi, sum_i);
			s.cy = fixed_quot(sum_yi, sum_i);
			s.mxx = fixed_quot(cxx < 0 ? 0 : cxx, sum_i);
			s.myy = fixed_quot(cyy < 0 ? 0 : cyy, sum_i);
			if (cxy < 0)
				s.mxy = -fixed_quot(-cxy, sum_i);
			else
				s.mxy = fixed_quot(cxy, sum_i);
		end else begin
			s.zs = 1'b1;
		end
		s.px = peak_c; s.py = peak_r;
		s.maxv = hi_val; s.minv = lo_val;
		summary_q.push_back(s);
		clear_sums();
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		summary_t s;
		if (!arst_n) begin
			width_reg = MAX_SIDE;
			height_reg = MAX_SIDE;
			clear_sums();
			summary_q.delete();
			errors <= 0;
			pending <= 0;
			frame_open <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_COLUMNS) width_reg = cfg_data;
				else height_reg = cfg_data;
			end
			if (pixel_valid && !pixel_stall) take_pixel(pixel);
			if (result_valid && !result_stall) begin
				if (summary_q.size() == 0) begin
					$error("summary word with none expected");
					errors++;
				end else begin
					s = summary_q.pop_front();
					check_field("centroid_x", s.cx, centroid_x);
					check_field("centroid_y", s.cy, centroid_y);
					check_field("moment_xx", s.mxx, moment_xx);
					check_field("moment_xy", $signed(s.mxy), moment_xy);
					check_field("moment_yy", s.myy, moment_yy);
					check_field("peak_x", s.px, peak_x);
					check_field("peak_y", s.py, peak_y);
					check_field("max_value", s.maxv, max_value);
					check_field("min_value", s.minv, min_value);
					check_field("zero_sum", s.zs, zero_sum);
				end
			end
			pending <= summary_q.size();
			frame_open <= (col != 0 || row != 0);
		end
	end
endmodule

// ===== test/tb_image_moments_peak_centered_top.sv =====
// ----------------------------------------------------------------------------
// tb_image_moments_peak_centered_top
// Drives frames of pixels of many sizes and intensity patterns into the
// moments block under random bursts and output stalls; a checker beside the
// block predicts each frame summary and counts mismatches.
// ----------------------------------------------------------------------------
module tb_image_moments_peak_centered_top;
	import imp_pkg::*;

	localparam int ITEM_TARGET = 1550;
	localparam int IDLE_LIMIT = 12000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0, cfg_index = 1'b0;
	logic [SIDE_W-1:0] cfg_data = '0;
	logic pixel_valid = 1'b0;
	logic [PIX_W-1:0] pixel = '0;
	logic result_stall = 1'b0;
	logic cfg_ready, pixel_stall, result_valid, zero_sum;
	logic [15:0] centroid_x, centroid_y, max_value, min_value;
	logic [23:0] moment_xx, moment_yy;
	logic signed [24:0] moment_xy;
	logic [7:0] peak_x, peak_y;
	int errors, pending;
	logic frame_open;

	logic hold_toggle = 1'b0, hold_seen = 1'b0;
	int hold_cnt, stall_mode, mode_cnt, idle_cycles;
	int burst_left, pixels_sent;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	image_moments_peak_centered_top u_top (.*);

	image_moments_checker u_checker (.*);

	// Receiver: stall density changes every so often; a toggle requests a long hold.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_cnt <= 0;
			stall_mode <= 0;
			mode_cnt <= 0;
		end else if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_cnt <= 2000;
			result_stall <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			result_stall <= (hold_cnt > 1);
		end else begin
			if (mode_cnt == 0) begin
				stall_mode <= $urandom_range(0, 2);
				mode_cnt <= $urandom_range(50, 400);
			end else begin
				mode_cnt <= mode_cnt - 1;
			end
			case (stall_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				default: result_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (pixel_valid && !pixel_stall)
				|| (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_reg(logic idx, logic [SIDE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic drain();
		do @(posedge clk); while (pending != 0);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_size(logic [SIDE_W-1:0] w, logic [SIDE_W-1:0] h);
		drain();
		write_reg(CFG_COLUMNS, w);
		write_reg(CFG_ROWS, h);
		cfg_valid <= 1'b0;
	endtask

	// Offers one word, leaving valid high for the next one in the burst.
	task automatic send_pixel(logic [PIX_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				pixel_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		pixel_valid <= 1'b1;
		pixel <= v;
		do @(posedge clk); while (pixel_stall);
		burst_left--;
		pixels_sent++;
	endtask

	function automatic logic [PIX_W-1:0] make_value(int style, int n);
		case (style)
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 3);
			3: return 16'hFFFF - n[15:0];
			4: return ($urandom_range(0, 7) == 0) ? 16'hFFFF : $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_frame(int w, int h, int style);
		for (int n = 0; n < w * h; n++) send_pixel(make_value(style, n));
		pixel_valid <= 1'b0;
	endtask

	// Sends single words until the checker sees the frame closed.
	task automatic finish_frame();
		do begin
			send_pixel($urandom);
			pixel_valid <= 1'b0;
			@(posedge clk);
		end while (frame_open);
	endtask

	initial begin
		int w, h, frames;
		logic [SIDE_W-1:0] wr, hr;
		burst_left = 0;
		pixels_sent = 0;
		idle_cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_size(1, 1);
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);
		send_pixel(16'h0001);
		pixel_valid <= 1'b0;
		set_size(0, 0);
		send_pixel(16'h5A5A);
		pixel_valid <= 1'b0;
		// Ties: only the first strict maximum moves the peak.
		set_size(2, 3);
		send_pixel(5); send_pixel(9); send_pixel(9);
		send_pixel(2); send_pixel(9); send_pixel(0);
		pixel_valid <= 1'b0;
		// Shrinking the height in mid-frame closes columns at once.
		set_size(3, 3);
		repeat (4) send_pixel($urandom);
		pixel_valid <= 1'b0;
		set_size(2, 1);
		finish_frame();

		set_size(256, 1);
		send_frame(256, 1, 5);
		set_size(1, 511);
		send_frame(1, 256, 3);

		frames = 0;
		while (pixels_sent < ITEM_TARGET) begin
			frames++;
			wr = $urandom_range(0, 6);
			hr = $urandom_range(0, 6);
			if ($urandom_range(0, 15) == 0) wr = $urandom_range(257, 511);
			if (wr > 256) hr = 1;
			if (frames >= 20 && frames < 26) begin
				wr = 1; hr = 1;
			end
			// Single-pixel frames keep coming during the long hold, so the size
			// is written only before the first of them.
			if (frames <= 20 || frames >= 26) set_size(wr, hr);
			w = (wr == 0) ? 1 : (wr > 256) ? 256 : wr;
			h = (hr == 0) ? 1 : hr;
			if (frames == 20) hold_toggle <= ~hold_toggle;
			if (frames >= 20 && frames < 26) begin
				send_pixel($urandom);
				if (frames == 25) pixel_valid <= 1'b0;
			end else if ($urandom_range(0, 9) == 0 && w * h > 2) begin
				repeat ($urandom_range(1, w * h - 1)) send_pixel($urandom);
				pixel_valid <= 1'b0;
				set_size($urandom_range(0, 4), $urandom_range(0, 4));
				finish_frame();
			end else begin
				send_frame(w, h, $urandom_range(0, 7));
			end
		end

		do @(posedge clk); while (pending != 0);
		repeat (400) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== image_moments_peak_centered_top.f =====
src/imp_pkg.sv
src/imp_div.sv
src/imp_final.sv
src/image_moments_peak_centered_top.sv
src/imp_checker.sv
test/image_moments_checker.sv
test/tb_image_moments_peak_centered_top.sv
